/* hw/rtl/fds_pkg.sv */
// Shared widths, codes and interface structs for the FDSelect lookup block.
package fds_pkg;

    localparam int POS_W   = 17;
    localparam int GLYPH_W = 16;
    localparam int DICT_W  = 8;
    localparam int ADDR_W  = 12;
    localparam int FMT_W   = 8;
    localparam int SIZE_W  = 13;

    // Item kinds carried in tuser.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Configuration register indexes.
    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_SIZE   = 1'b1;

    // Table formats with a defined meaning.
    localparam logic [FMT_W-1:0] FMT_ARRAY  = 8'd0;
    localparam logic [FMT_W-1:0] FMT_RANGES = 8'd3;

    // Byte read request to the table store.
    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] pos;
    } fds_rd_req_t;

    // Result of the shared subtractor: a - b and its borrow (a < b).
    typedef struct packed {
        logic             borrow;
        logic [POS_W-1:0] diff;
    } fds_alu_res_t;

    // Control from the top level to the lookup sequencer.
    typedef struct packed {
        logic start;
        logic cache_clear;
        logic res_take;
    } fds_wctl_t;

    // Status from the lookup sequencer to the top level.
    typedef struct packed {
        logic              busy;
        logic              res_valid;
        logic [DICT_W-1:0] res_dict;
    } fds_wstat_t;

endpackage

/* hw/rtl/fd_select_lookup.sv */
// Top level of the FDSelect lookup block: stream ports, configuration and result register.
//
// This block maps a glyph number to a font-dictionary number through an FDSelect table held
// in an internal byte store of TABLE_BYTES entries. Each input item is either a table byte
// write (tuser low) or a glyph lookup (tuser high); a write gives no result and a lookup gives
// exactly one. Lookups are handled one at a time by a small sequencer that drives one shared
// subtract/compare unit and the store's single read port, so the input side is not ready while
// a lookup is in progress. A format 0 lookup reads the byte at the glyph's position. A format 3
// lookup first tests the one-range cache; on a miss it walks the ranges from the table's first
// glyph, reading each range's dictionary byte and the next range's first glyph (one store
// byte per cycle plus the compares on the shared unit); it answers 0 when the glyph lies in
// front of a range's first glyph or the walk reaches the table size, and any other format
// answers 0 without reading the table. The result reaches the output
// register at the same edge that reopens the input side, and waits there while the next item
// is taken in. The two configuration registers (format, size) are taken at any time through
// their own write channel but are meant to be written while the block is idle; any table
// write, or configuration write made while the sequencer is idle, empties the range cache.
// Bytes at or past the table size read as zero.
module fd_select_lookup
    import fds_pkg::*;
#(
    parameter int TABLE_BYTES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // byte_address[11:0], byte_value[19:12], glyph[35:20], zeros
    input  logic        s_tuser,   // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // dict_number[7:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    localparam logic [POS_W-1:0] DEPTH = POS_W'(TABLE_BYTES);

    logic                in_accept;
    logic                wr_item;
    logic                cfg_accept;
    logic [FMT_W-1:0]    format_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [POS_W-1:0]    size_ext;
    logic [POS_W-1:0]    eff_size;
    logic                m_tvalid_reg;
    logic [DICT_W-1:0]   m_tdata_reg;
    fds_wctl_t           wctl;
    fds_wstat_t          wstat;
    fds_rd_req_t         rd_req;
    logic [7:0]          rd_byte;
    logic [POS_W-1:0]    alu_a;
    logic [POS_W-1:0]    alu_b;
    fds_alu_res_t        alu_res;

    // Input fields.
    logic [ADDR_W-1:0]   byte_address;
    logic [7:0]          byte_value;
    logic [GLYPH_W-1:0]  glyph;

    assign byte_address = s_tdata[11:0];
    assign byte_value   = s_tdata[19:12];
    assign glyph        = s_tdata[35:20];

    // The input side is open whenever the sequencer is idle.
    assign s_tready  = !wstat.busy;
    assign in_accept = s_tvalid && s_tready;
    assign wr_item   = in_accept && (s_tuser == OP_WRITE);

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    // A size beyond the store is clamped to the store depth.
    assign size_ext = POS_W'(size_reg);
    assign eff_size = (size_ext > DEPTH) ? DEPTH : size_ext;

    assign wctl.start       = in_accept && (s_tuser == OP_LOOKUP);
    assign wctl.cache_clear = wr_item || cfg_accept;
    assign wctl.res_take    = wstat.res_valid && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= '0;
            size_reg   <= '0;
        end
        else if (cfg_accept)
        begin
            case (cfg_index)
                REG_FORMAT: format_reg <= cfg_data[FMT_W-1:0];
                REG_SIZE:   size_reg   <= cfg_data;
                default:    format_reg <= format_reg;
            endcase
        end
    end

    // Output register: the result waits here while the next item is taken in.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (wctl.res_take)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wctl.res_take)
        begin
            m_tdata_reg <= wstat.res_dict;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    fds_store #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_item),
        .wr_addr (byte_address),
        .wr_data (byte_value),
        .rd_req  (rd_req),
        .size    (eff_size),
        .rd_byte (rd_byte)
    );

    fds_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    fds_walker u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (wctl),
        .glyph        (glyph),
        .table_format (format_reg),
        .eff_size     (eff_size),
        .rd_req       (rd_req),
        .rd_byte      (rd_byte),
        .alu_a        (alu_a),
        .alu_b        (alu_b),
        .alu_res      (alu_res),
        .stat         (wstat)
    );

    // A table write never starts the sequencer.
    a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wr_item |=> !wstat.busy)
        else $error("table write started a lookup");

    // An accepted lookup always occupies the sequencer in the next cycle.
    a_lookup_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wctl.start |=> wstat.busy)
        else $error("lookup accepted but sequencer idle");

    // A pending result only exists while the sequencer is holding it.
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wstat.res_valid |-> wstat.busy && !s_tready)
        else $error("result pending while input open");

    // A handed-over result shows up on the output in the next cycle.
    a_take_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        wctl.res_take |=> m_tvalid && !wstat.busy)
        else $error("taken result not presented");

endmodule

/* hw/rtl/fds_store.sv */
// Table byte store with one write port and one registered, range-checked read port.
module fds_store
    import fds_pkg::*;
#(
    parameter int TABLE_BYTES = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  fds_rd_req_t       rd_req,
    input  logic [POS_W-1:0]  size,
    output logic [7:0]        rd_byte
);

    localparam int AW = $clog2(TABLE_BYTES);
    localparam logic [POS_W-1:0] DEPTH = POS_W'(TABLE_BYTES);

    logic [7:0]       mem [TABLE_BYTES];
    logic [7:0]       mem_q_reg;
    logic             in_range_reg;
    logic [POS_W-1:0] wr_pos;
    logic             wr_ok;

    assign wr_pos = POS_W'(wr_addr);
    assign wr_ok  = wr_en && (wr_pos < DEPTH);

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wr_pos[AW-1:0]] <= wr_data;
        end
        if (rd_req.en)
        begin
            mem_q_reg <= mem[rd_req.pos[AW-1:0]];
        end
    end

    // Bytes at or past the table size read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_range_reg <= 1'b0;
        end
        else if (rd_req.en)
        begin
            in_range_reg <= (rd_req.pos < size);
        end
    end

    assign rd_byte = in_range_reg ? mem_q_reg : 8'd0;

endmodule

/* hw/rtl/fds_alu.sv */
// Shared subtract and compare unit used by the lookup sequencer.
module fds_alu
    import fds_pkg::*;
(
    input  logic [POS_W-1:0] a,
    input  logic [POS_W-1:0] b,
    output fds_alu_res_t     res
);

    assign res = {1'b0, a} - {1'b0, b};

endmodule

/* hw/rtl/fds_walker.sv */
// Lookup sequencer: range cache, format 0 read and format 3 range walk.
module fds_walker
    import fds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  fds_wctl_t          ctl,
    input  logic [GLYPH_W-1:0] glyph,
    input  logic [FMT_W-1:0]   table_format,
    input  logic [POS_W-1:0]   eff_size,
    output fds_rd_req_t        rd_req,
    input  logic [7:0]         rd_byte,
    output logic [POS_W-1:0]   alu_a,
    output logic [POS_W-1:0]   alu_b,
    input  fds_alu_res_t       alu_res,
    output fds_wstat_t         stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_F0_RD,
        S_F0_WAIT,
        S_C_FIRST,
        S_C_COUNT,
        S_W_HI,
        S_W_LO,
        S_W_END,
        S_W_TEST,
        S_W_DICT,
        S_W_LHI,
        S_W_LLO,
        S_W_LIM,
        S_W_POS,
        S_W_HIT,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [GLYPH_W-1:0] glyph_reg, glyph_next;
    logic [GLYPH_W-1:0] first_reg, first_next;
    logic [GLYPH_W-1:0] limit_reg, limit_next;
    logic [DICT_W-1:0]  dict_reg, dict_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [GLYPH_W-1:0] diff_reg, diff_next;
    logic [DICT_W-1:0]  result_reg, result_next;
    logic [GLYPH_W-1:0] cached_first_reg, cached_first_next;
    logic [GLYPH_W-1:0] cached_count_reg, cached_count_next;
    logic [DICT_W-1:0]  cached_dict_reg, cached_dict_next;

    always_comb
    begin
        state_next        = state_reg;
        glyph_next        = glyph_reg;
        first_next        = first_reg;
        limit_next        = limit_reg;
        dict_next         = dict_reg;
        pos_next          = pos_reg;
        diff_next         = diff_reg;
        result_next       = result_reg;
        cached_first_next = cached_first_reg;
        cached_count_next = cached_count_reg;
        cached_dict_next  = cached_dict_reg;
        rd_req            = '0;
        alu_a             = POS_W'(glyph_reg);
        alu_b             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (ctl.cache_clear)
                begin
                    cached_count_next = '0;
                end
                if (ctl.start)
                begin
                    glyph_next = glyph;
                    if (table_format == FMT_ARRAY)
                    begin
                        state_next = S_F0_RD;
                    end
                    else if (table_format == FMT_RANGES)
                    begin
                        state_next = S_C_FIRST;
                    end
                    else
                    begin
                        result_next = '0;
                        state_next  = S_DONE;
                    end
                end
            end
            S_F0_RD:
            begin
                rd_req.en  = 1'b1;
                rd_req.pos = POS_W'(glyph_reg);
                state_next = S_F0_WAIT;
            end
            S_F0_WAIT:
            begin
                result_next = rd_byte;
                state_next  = S_DONE;
            end
            S_C_FIRST:
            begin
                alu_b = POS_W'(cached_first_reg);
                if (alu_res.borrow)
                begin
                    state_next = S_W_HI;
                end
                else
                begin
                    diff_next  = alu_res.diff[GLYPH_W-1:0];
                    state_next = S_C_COUNT;
                end
            end
            S_C_COUNT:
            begin
                alu_a = POS_W'(diff_reg);
                alu_b = POS_W'(cached_count_reg);
                if (alu_res.borrow)
                begin
                    result_next = cached_dict_reg;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_W_HI;
                end
            end
            S_W_HI:
            begin
                rd_req.en  = 1'b1;
                rd_req.pos = '0;
                state_next = S_W_LO;
            end
            S_W_LO:
            begin
                rd_req.en  = 1'b1;
                rd_req.pos = POS_W'(1);
                first_next = {rd_byte, first_reg[7:0]};
                state_next = S_W_END;
            end
            S_W_END:
            begin
                first_next = {first_reg[15:8], rd_byte};
                pos_next   = POS_W'(2);
                state_next = S_W_TEST;
            end
            S_W_TEST:
            begin
                alu_b      = POS_W'(first_reg);
                rd_req.en  = 1'b1;
                rd_req.pos = pos_reg;
                if (alu_res.borrow)
                begin
                    result_next = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_W_DICT;
                end
            end
            S_W_DICT:
            begin
                dict_next  = rd_byte;
                rd_req.en  = 1'b1;
                rd_req.pos = pos_reg + POS_W'(1);
                state_next = S_W_LHI;
            end
            S_W_LHI:
            begin
                limit_next = {rd_byte, limit_reg[7:0]};
                rd_req.en  = 1'b1;
                rd_req.pos = pos_reg + POS_W'(2);
                state_next = S_W_LLO;
            end
            S_W_LLO:
            begin
                limit_next = {limit_reg[15:8], rd_byte};
                pos_next   = pos_reg + POS_W'(3);
                state_next = S_W_LIM;
            end
            S_W_LIM:
            begin
                alu_b = POS_W'(limit_reg);
                if (alu_res.borrow)
                begin
                    state_next = S_W_HIT;
                end
                else
                begin
                    first_next = limit_reg;
                    state_next = S_W_POS;
                end
            end
            S_W_POS:
            begin
                alu_a = pos_reg;
                alu_b = eff_size;
                if (alu_res.borrow)
                begin
                    state_next = S_W_TEST;
                end
                else
                begin
                    result_next = '0;
                    state_next  = S_DONE;
                end
            end
            S_W_HIT:
            begin
                alu_a             = POS_W'(limit_reg);
                alu_b             = POS_W'(first_reg);
                cached_first_next = first_reg;
                cached_count_next = alu_res.diff[GLYPH_W-1:0];
                cached_dict_next  = dict_reg;
                result_next       = dict_reg;
                state_next        = S_DONE;
            end
            S_DONE:
            begin
                if (ctl.res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cached_first_reg <= '0;
            cached_count_reg <= '0;
            cached_dict_reg  <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cached_first_reg <= cached_first_next;
            cached_count_reg <= cached_count_next;
            cached_dict_reg  <= cached_dict_next;
        end
    end

    always_ff @(posedge clk)
    begin
        glyph_reg  <= glyph_next;
        first_reg  <= first_next;
        limit_reg  <= limit_next;
        dict_reg   <= dict_next;
        pos_reg    <= pos_next;
        diff_reg   <= diff_next;
        result_reg <= result_next;
    end

    assign stat.busy      = (state_reg != S_IDLE);
    assign stat.res_valid = (state_reg == S_DONE);
    assign stat.res_dict  = result_reg;

endmodule
